### rtl/core/char_lcd_nibble_writer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the character display nibble writer
// Concurrent checks on clk, disabled while the reset is high.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_WRITER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property must hold at every edge out of reset
`define CLNW_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// condition must never be seen out of reset
`define CLNW_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define CLNW_ASSERT(label, clk, rst, prop)
`define CLNW_NEVER(label, clk, rst, cond)

`endif

`endif

### rtl/core/clnw_pkg.sv
// ----------------------------------------------------------------------------
// clnw_pkg
// Types and constants shared by the nibble writer controller and datapath.
// ----------------------------------------------------------------------------
package clnw_pkg;

  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BIN_BITS   = 32;
  localparam int unsigned BCD_BITS   = 4 * NUM_DIGITS;

  localparam logic [7:0] ASCII_ZERO = 8'd48;

  typedef enum logic [1:0] {
    KIND_CMD    = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_CURSOR = 2'd2,
    KIND_NUMBER = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_HIGH,
    ST_LOW
  } state_t;

  typedef struct packed {
    logic load;       // capture a new request
    logic conv_step;  // one shift-add-3 step of the decimal conversion
    logic dec_idx;    // move to the next lower digit
    logic emit_low;   // drive the low nibble instead of the high one
  } cmd_t;

  typedef struct packed {
    logic conv_last;  // final conversion step is under way
    logic lead_zero;  // current digit is a leading zero that can be dropped
    logic last_byte;  // current byte is the final one of the request
  } status_t;

endpackage

### rtl/core/clnw_datapath.sv
// ----------------------------------------------------------------------------
// clnw_datapath
// Request registers, bit-serial binary to BCD converter and nibble selection.
// ----------------------------------------------------------------------------
module clnw_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  clnw_pkg::cmd_t            cmd,
  output clnw_pkg::status_t         status,
  input  clnw_pkg::kind_t           kind,
  input  logic [7:0]                byte_value,
  input  logic                      row,
  input  logic [5:0]                column,
  input  logic [31:0]               number,
  output logic [3:0]                nibble,
  output logic                      reg_select,
  output logic                      last
);
  import clnw_pkg::*;

  logic [7:0]          byte_reg;
  logic                rs;
  logic                is_num;
  logic [BCD_BITS-1:0] bcd;
  logic [BIN_BITS-1:0] bin;
  logic [4:0]          count;
  logic [3:0]          idx;

  logic [BCD_BITS-1:0] bcd_adj;
  logic [3:0]          digit;
  logic [7:0]          cur_byte;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  assign digit    = bcd[{idx, 2'b00} +: 4];
  assign cur_byte = is_num ? (ASCII_ZERO + {4'd0, digit}) : byte_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load) begin
      count <= '0;
    end else if (cmd.conv_step) begin
      count <= count + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_num <= (kind == KIND_NUMBER);
      rs     <= (kind == KIND_CHAR) || (kind == KIND_NUMBER);
      bcd    <= '0;
      bin    <= number;
      idx    <= 4'(NUM_DIGITS - 1);
      case (kind)
        KIND_CMD, KIND_CHAR: byte_reg <= byte_value;
        KIND_CURSOR:         byte_reg <= {1'b1, row, column};
        default:             byte_reg <= '0;
      endcase
    end else begin
      if (cmd.conv_step) begin
        {bcd, bin} <= {bcd_adj[BCD_BITS-2:0], bin, 1'b0};
      end
      if (cmd.dec_idx) begin
        idx <= idx - 4'd1;
      end
    end
  end

  assign status.conv_last = (count == 5'd31);
  assign status.lead_zero = (digit == 4'd0) && (idx != 4'd0);
  assign status.last_byte = !is_num || (idx == 4'd0);

  assign nibble     = cmd.emit_low ? cur_byte[3:0] : cur_byte[7:4];
  assign reg_select = rs;
  assign last       = cmd.emit_low && status.last_byte;

endmodule

### rtl/core/clnw_ctrl.sv
// ----------------------------------------------------------------------------
// clnw_ctrl
// Sequencer: capture, decimal conversion, leading zero skip, nibble output.
// ----------------------------------------------------------------------------
`include "char_lcd_nibble_writer_defines.svh"

module clnw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  clnw_pkg::kind_t     kind,
  output logic                out_valid,
  input  logic                out_ready,
  output clnw_pkg::cmd_t      cmd,
  input  clnw_pkg::status_t   status
);
  import clnw_pkg::*;

  state_t state, state_next;
  logic   in_fire;
  logic   out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (kind == KIND_NUMBER) ? ST_CONVERT : ST_HIGH;
        end
      end
      ST_CONVERT: begin
        if (status.conv_last) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!status.lead_zero) begin
          state_next = ST_HIGH;
        end
      end
      ST_HIGH: begin
        if (out_ready) begin
          state_next = ST_LOW;
        end
      end
      ST_LOW: begin
        if (out_ready) begin
          state_next = status.last_byte ? ST_IDLE : ST_HIGH;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONVERT: cmd.conv_step = 1'b1;
      ST_SKIP:    cmd.dec_idx = status.lead_zero;
      ST_HIGH:    out_valid = 1'b1;
      ST_LOW: begin
        out_valid    = 1'b1;
        cmd.emit_low = 1'b1;
        cmd.dec_idx  = out_ready && !status.last_byte;
      end
      default: ;
    endcase
  end

  `CLNW_NEVER(a_no_overlap, clk, rst, in_ready && out_valid)
  `CLNW_ASSERT(a_byte_kinds_emit, clk, rst, (in_fire && kind != KIND_NUMBER) |=> (state == ST_HIGH))
  `CLNW_ASSERT(a_conv_to_skip, clk, rst, (state == ST_CONVERT && status.conv_last) |=> (state == ST_SKIP))
  `CLNW_ASSERT(a_last_frees_input, clk, rst, (out_fire && cmd.emit_low && status.last_byte) |=> in_ready)

endmodule

### rtl/core/char_lcd_nibble_writer.sv
// Command, character and cursor requests show the first nibble in the cycle after accept.
// Numbers: after accept the decimal conversion runs, then each leading zero is dropped before the first nibble.
// Each byte goes out as two nibbles, one per cycle while out_ready is high; 2 to 20 per request.
// One request at a time: a new request is taken only after the last nibble of the previous one has gone out.
// Reset: synchronous, active high; returns the sequencer to idle, ready for a request.
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// Turns display requests into 4-bit bus words with register select.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  byte_value,
  input  logic        row,
  input  logic [5:0]  column,
  input  logic [31:0] number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  nibble,
  output logic        reg_select,
  output logic        last
);
  import clnw_pkg::*;

  cmd_t    cmd;
  status_t status;
  kind_t   kind_in;

  assign kind_in = kind_t'(kind);

  clnw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  clnw_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .kind       (kind_in),
    .byte_value (byte_value),
    .row        (row),
    .column     (column),
    .number     (number),
    .nibble     (nibble),
    .reg_select (reg_select),
    .last       (last)
  );

endmodule

### tb/sv/tb_char_lcd_nibble_writer.sv
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_writer
// Drives command, character, cursor and decimal requests into the nibble
// writer with random idle gaps on both handshakes. A directed table runs
// first, then random requests; every output word is compared field by field
// against a software prediction of the 4-bit transfer sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_char_lcd_nibble_writer;
  import clnw_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RAND_WORDS  = 209;
  localparam int unsigned SETTLE      = 70;
  localparam logic [7:0]  TOP_LINE    = 8'h80;
  localparam logic [7:0]  BOTTOM_LINE = 8'hC0;

  typedef struct packed {
    logic [3:0] nib;
    logic       rs;
    logic       fin;
  } xfer_t;

  typedef struct {
    kind_t       k;
    logic [7:0]  b;
    logic        r;
    logic [5:0]  c;
    logic [31:0] n;
    bit          typed;  // single expected byte given in the row
    logic [7:0]  eb;
    bit          ers;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  kind;
  logic [7:0]  byte_value;
  logic        row;
  logic [5:0]  column;
  logic [31:0] number;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  nibble;
  logic        reg_select;
  logic        last;

  // travel with the payload so the monitor sees them at acceptance
  bit          chk_typed;
  logic [7:0]  chk_byte;
  bit          chk_rs;

  bit          steady;
  int          errors;
  xfer_t       xfer_q[$];

  stim_row_t dir_tab [21] = '{
    '{KIND_CMD,    8'h00, 1'b0, 6'd0,  32'd0,          1'b1, 8'h00, 1'b0},
    '{KIND_CMD,    8'hFF, 1'b1, 6'd63, 32'hFFFF_FFFF,  1'b1, 8'hFF, 1'b0},
    '{KIND_CHAR,   8'h00, 1'b1, 6'd63, 32'hFFFF_FFFF,  1'b1, 8'h00, 1'b1},
    '{KIND_CHAR,   8'hFF, 1'b0, 6'd0,  32'd0,          1'b1, 8'hFF, 1'b1},
    '{KIND_CHAR,   8'h5A, 1'b1, 6'd42, 32'h1234_5678,  1'b0, 8'h00, 1'b0},
    '{KIND_CMD,    8'hA5, 1'b0, 6'd21, 32'hDEAD_BEEF,  1'b0, 8'h00, 1'b0},
    '{KIND_CURSOR, 8'hFF, 1'b0, 6'd0,  32'hFFFF_FFFF,  1'b1, 8'h80, 1'b0},
    '{KIND_CURSOR, 8'h00, 1'b1, 6'd63, 32'd0,          1'b1, 8'hFF, 1'b0},
    '{KIND_CURSOR, 8'h00, 1'b0, 6'd63, 32'd0,          1'b1, 8'hBF, 1'b0},
    '{KIND_CURSOR, 8'hFF, 1'b1, 6'd0,  32'd0,          1'b1, 8'hC0, 1'b0},
    '{KIND_CURSOR, 8'h3C, 1'b1, 6'd21, 32'h8000_0001,  1'b0, 8'h00, 1'b0},
    '{KIND_NUMBER, 8'hFF, 1'b1, 6'd63, 32'd0,          1'b1, 8'h30, 1'b1},
    '{KIND_NUMBER, 8'h00, 1'b0, 6'd0,  32'd9,          1'b1, 8'h39, 1'b1},
    '{KIND_NUMBER, 8'h00, 1'b0, 6'd0,  32'd10,         1'b0, 8'h00, 1'b0},
    '{KIND_NUMBER, 8'h77, 1'b1, 6'd7,  32'd99,         1'b0, 8'h00, 1'b0},
    '{KIND_NUMBER, 8'h00, 1'b0, 6'd0,  32'd100,        1'b0, 8'h00, 1'b0},
    '{KIND_NUMBER, 8'h00, 1'b0, 6'd0,  32'd999999999,  1'b0, 8'h00, 1'b0},
    '{KIND_NUMBER, 8'h00, 1'b0, 6'd0,  32'd1000000000, 1'b0, 8'h00, 1'b0},
    '{KIND_NUMBER, 8'h00, 1'b1, 6'd63, 32'hFFFF_FFFF,  1'b0, 8'h00, 1'b0},
    '{KIND_NUMBER, 8'hFF, 1'b0, 6'd0,  32'h8000_0000,  1'b0, 8'h00, 1'b0},
    '{KIND_NUMBER, 8'h00, 1'b0, 6'd0,  32'hFFFF_FFFE,  1'b0, 8'h00, 1'b0}
  };

  char_lcd_nibble_writer dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .byte_value (byte_value),
    .row        (row),
    .column     (column),
    .number     (number),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .nibble     (nibble),
    .reg_select (reg_select),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one byte on the bus: high nibble, then low nibble
  function automatic void queue_byte(logic [7:0] b, logic rs, logic fin);
    xfer_q.push_back('{nib: b[7:4], rs: rs, fin: 1'b0});
    xfer_q.push_back('{nib: b[3:0], rs: rs, fin: fin});
  endfunction

  function automatic void predict_transfers(kind_t k, logic [7:0] b, logic r,
                                            logic [5:0] c, logic [31:0] n);
    logic [3:0]  dig [10];
    logic [31:0] v;
    int          nd;
    case (k)
      KIND_CMD:    queue_byte(b, 1'b0, 1'b1);
      KIND_CHAR:   queue_byte(b, 1'b1, 1'b1);
      KIND_CURSOR: queue_byte((r ? BOTTOM_LINE : TOP_LINE) + {2'b00, c}, 1'b0, 1'b1);
      default: begin
        // split into decimal digits, least significant first; zero keeps one
        v  = n;
        nd = 0;
        do begin
          dig[nd] = 4'(v % 10);
          v       = v / 10;
          nd++;
        end while (v != 0 && nd < 10);
        for (int i = nd - 1; i >= 0; i--)
          queue_byte(ASCII_ZERO + {4'd0, dig[i]}, 1'b1, i == 0);
      end
    endcase
  endfunction

  // sample both handshakes on the same edge: predict first, then check
  always @(posedge clk) begin
    xfer_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (chk_typed)
          queue_byte(chk_byte, chk_rs, 1'b1);
        else
          predict_transfers(kind_t'(kind), byte_value, row, column, number);
      end
      if (out_valid && out_ready) begin
        if (xfer_q.size() == 0) begin
          $display("%0t: unexpected word nibble=%h reg_select=%b last=%b",
                   $time, nibble, reg_select, last);
          errors++;
        end else begin
          want = xfer_q.pop_front();
          if (nibble !== want.nib) begin
            $display("%0t: nibble expected %h actual %h", $time, want.nib, nibble);
            errors++;
          end
          if (reg_select !== want.rs) begin
            $display("%0t: reg_select expected %b actual %b", $time, want.rs, reg_select);
            errors++;
          end
          if (last !== want.fin) begin
            $display("%0t: last expected %b actual %b", $time, want.fin, last);
            errors++;
          end
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stalls: mostly short, now and then long
  initial begin
    int hold;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (!steady && $urandom_range(0, 99) < 25) begin
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_word(input kind_t k, input logic [7:0] b, input logic r,
                           input logic [5:0] c, input logic [31:0] n,
                           input bit typed, input logic [7:0] eb, input bit ers);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    byte_value <= b;
    row        <= r;
    column     <= c;
    number     <= n;
    chk_typed  <= typed;
    chk_byte   <= eb;
    chk_rs     <= ers;
    // hold until accepted
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (xfer_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_number();
    logic [31:0] p;
    int          r;
    r = $urandom_range(0, 9);
    if (r < 3)
      return $urandom_range(0, 99);
    if (r == 3)
      return 32'd0;
    if (r == 4) begin
      // land on or just below a power of ten
      p = 32'd1;
      repeat ($urandom_range(0, 9)) p = p * 10;
      return p - $urandom_range(0, 1);
    end
    return $urandom();
  endfunction

  function automatic kind_t rand_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2)
      return KIND_CMD;
    if (r < 4)
      return KIND_CHAR;
    if (r < 6)
      return KIND_CURSOR;
    return KIND_NUMBER;
  endfunction

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    int spin;
    errors      = 0;
    steady      = 1'b0;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    kind       <= KIND_CMD;
    byte_value <= 8'h00;
    row        <= 1'b0;
    column     <= 6'd0;
    number     <= 32'd0;
    chk_typed  <= 1'b0;
    chk_byte   <= 8'h00;
    chk_rs     <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i])
      send_word(dir_tab[i].k, dir_tab[i].b, dir_tab[i].r, dir_tab[i].c, dir_tab[i].n,
                dir_tab[i].typed, dir_tab[i].eb, dir_tab[i].ers);
    wait_drained();

    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i == 115)
        wait_drained();
      // back-to-back stretch with no stalls on either side
      steady = (i >= 150 && i < 190);
      send_word(rand_kind(), 8'($urandom()), 1'($urandom()), 6'($urandom()),
                rand_number(), 1'b0, 8'h00, 1'b0);
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    spin = 0;
    @(posedge clk);
    while (xfer_q.size() != 0 && spin < 20000) begin
      @(posedge clk);
      spin++;
    end
    repeat (SETTLE) @(posedge clk);
    if (xfer_q.size() != 0) begin
      $display("%0t: %0d words expected but never seen", $time, xfer_q.size());
      errors++;
    end

    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
